>>> src/kpc_pkg.sv
// kpc_pkg: shared types, constants and helpers for the key press classifier
// used by kpc_core and key_press_classifier; no dependencies
package kpc_pkg;

	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CONFIRM  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_MIN        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_MAX        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_RELEASE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MIN     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MAX     = 3'd6;

	// reset values of the thresholds
	localparam logic [CNT_W-1:0] RST_PRESS_CONFIRM = 16'd30;
	localparam logic [CNT_W-1:0] RST_GAP_MIN       = 16'd10;
	localparam logic [CNT_W-1:0] RST_GAP_MAX       = 16'd200;
	localparam logic [CNT_W-1:0] RST_LONG_PRESS    = 16'd1000;
	localparam logic [CNT_W-1:0] RST_LONG_RELEASE  = 16'd20;
	localparam logic [CNT_W-1:0] RST_SECOND_MIN    = 16'd30;
	localparam logic [CNT_W-1:0] RST_SECOND_MAX    = 16'd500;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SHORT  = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} kpc_event_t;

	typedef struct packed {
		logic [CNT_W-1:0] press_confirm;
		logic [CNT_W-1:0] gap_min;
		logic [CNT_W-1:0] gap_max;
		logic [CNT_W-1:0] long_press;
		logic [CNT_W-1:0] long_release;
		logic [CNT_W-1:0] second_min;
		logic [CNT_W-1:0] second_max;
	} kpc_cfg_t;

	typedef struct packed {
		kpc_event_t       latched;
		logic             first_press;
		logic [CNT_W-1:0] released_count;
	} kpc_status_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
	endfunction

endpackage

>>> src/kpc_core.sv
// kpc_core: press counters, flags and event latch, updated once per transfer
// depends on kpc_pkg
module kpc_core
	import kpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_valid,
	input  logic        step_action,
	input  logic        step_pin,
	input  kpc_cfg_t    cfg,
	output kpc_event_t  result,
	output kpc_status_t status
);

	logic [CNT_W-1:0] pressed_q, released_q, second_q;
	logic [CNT_W-1:0] pressed_n, released_n, second_n;
	logic             first_q, second_flag_q, first_n, second_flag_n;
	kpc_event_t       event_q, event_n;

	always_comb begin
		pressed_n     = pressed_q;
		released_n    = released_q;
		second_n      = second_q;
		first_n       = first_q;
		second_flag_n = second_flag_q;
		event_n       = event_q;
		result        = event_q;
		if (step_action) begin
			// read returns the old event and clears it
			event_n = EV_NONE;
		end else begin
			if (!step_pin) begin
				pressed_n = sat_inc(pressed_q);
				if (pressed_n >= cfg.press_confirm) begin
					first_n = 1'b1;
				end
				if (released_q > cfg.gap_min && released_q < cfg.gap_max && first_n) begin
					second_flag_n = 1'b1;
					second_n      = sat_inc(second_q);
				end
			end else if (first_q) begin
				released_n = sat_inc(released_q);
				if (pressed_q < cfg.long_press && released_n > cfg.gap_max) begin
					event_n    = EV_SHORT;
					pressed_n  = '0;
					released_n = '0;
					second_n   = '0;
					first_n    = 1'b0;
				end else if (second_flag_q && second_q > cfg.second_min
						&& second_q < cfg.second_max) begin
					event_n       = EV_DOUBLE;
					pressed_n     = '0;
					released_n    = '0;
					second_n      = '0;
					first_n       = 1'b0;
					second_flag_n = 1'b0;
				end
			end
			// long press check sees the counts after any clear above
			if (pressed_n >= cfg.long_press && released_n > cfg.long_release) begin
				event_n    = EV_LONG;
				pressed_n  = '0;
				released_n = '0;
				second_n   = '0;
				first_n    = 1'b0;
			end
			result = event_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q     <= '0;
			released_q    <= '0;
			second_q      <= '0;
			first_q       <= 1'b0;
			second_flag_q <= 1'b0;
			event_q       <= EV_NONE;
		end else if (step_valid) begin
			pressed_q     <= pressed_n;
			released_q    <= released_n;
			second_q      <= second_n;
			first_q       <= first_n;
			second_flag_q <= second_flag_n;
			event_q       <= event_n;
		end
	end

	assign status = '{latched: event_q, first_press: first_q, released_count: released_q};

endmodule

>>> src/key_press_classifier.sv
// key_press_classifier: top level with handshake, threshold registers and result register
// depends on kpc_pkg and kpc_core
//
// Classifies an active-low button sampled once per tick item into short, double or long
// press, and returns the latched event (0 none, 1 short, 2 double, 3 long) for every item;
// a read item (action high) returns the latch and clears it. One item is taken every cycle
// while in_stall is low: a transfer lands in an input register, and the counters, event
// latch and result register update when the item leaves that register. A stalled result
// holds the input register, and in_stall then follows out_stall. The user writes the
// thresholds via the cfg port while no item is in flight; the block does not enforce it.
module key_press_classifier
	import kpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	input  logic                 pin_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           event_code,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	kpc_cfg_t    cfg_q;
	kpc_status_t status;
	kpc_event_t  result;
	kpc_event_t  event_q;
	logic        valid_s1, action_s1, pin_s1;
	logic        out_valid_q;
	logic        out_free, advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{press_confirm: RST_PRESS_CONFIRM, gap_min: RST_GAP_MIN,
				gap_max: RST_GAP_MAX, long_press: RST_LONG_PRESS,
				long_release: RST_LONG_RELEASE, second_min: RST_SECOND_MIN,
				second_max: RST_SECOND_MAX};
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PRESS_CONFIRM: cfg_q.press_confirm <= cfg_data;
				CFG_GAP_MIN:       cfg_q.gap_min       <= cfg_data;
				CFG_GAP_MAX:       cfg_q.gap_max       <= cfg_data;
				CFG_LONG_PRESS:    cfg_q.long_press    <= cfg_data;
				CFG_LONG_RELEASE:  cfg_q.long_release  <= cfg_data;
				CFG_SECOND_MIN:    cfg_q.second_min    <= cfg_data;
				CFG_SECOND_MAX:    cfg_q.second_max    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			pin_s1    <= pin_level;
		end
		if (advance) begin
			event_q <= result;
		end
	end

	kpc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_valid  (advance),
		.step_action (action_s1),
		.step_pin    (pin_s1),
		.cfg         (cfg_q),
		.result      (result),
		.status      (status)
	);

	assign out_valid  = out_valid_q;
	assign event_code = event_q;

	// a read transfer always leaves the latch empty
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 |=> status.latched == EV_NONE)
		else $error("event latch not cleared after read");

	// release ticks are only counted after a confirmed first press
	a_release_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		!status.first_press |-> status.released_count == '0)
		else $error("release count running without a confirmed press");

	// every processed item produces a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed item lost its result");

	// a tick result equals the latch it leaves behind
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !action_s1 |=> event_q == status.latched)
		else $error("tick result differs from latched event");

endmodule
